// ===== rtl/lae_pkg.sv =====
`timescale 1ns / 1ps
// lae_pkg: shared types and constants for the LMS adaptive equalizer.
// No dependencies; used by the controller, datapath and top level.

package lae_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;   // Q1.15 sample / desired / filtered
    localparam int COEF_W   = 32;   // Q5.27 coefficient
    localparam int ERR_W    = 17;   // Q2.15 error
    localparam int MU_W     = 16;   // Q0.16 step size
    localparam int TAPS_W   = 6;    // taps_in_use register
    localparam int ME_W     = 33;   // mu * error
    localparam int PROD_W   = 49;   // shared multiplier result

    // Rounding for the filter sum (Q.42 -> Q1.15) and the coefficient delta
    localparam int Y_SHIFT  = 27;
    localparam int D_SHIFT  = 19;
    localparam int D_W      = PROD_W - D_SHIFT;

    // Register map (index = paddr / 4)
    localparam int          PADDR_W    = 4;
    localparam logic [1:0]  REG_ADAPT  = 2'd0;
    localparam logic [1:0]  REG_STEP   = 2'd1;
    localparam logic [1:0]  REG_TAPS   = 2'd2;

    // Register reset values
    localparam logic          ADAPT_RST = 1'b1;
    localparam logic [MU_W-1:0] STEP_RST = 16'd328;
    localparam logic [TAPS_W-1:0] TAPS_RST = 6'd32;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;     // take sample into tap line, clear accumulator
        logic issue;      // read tap/coef at the current index
        logic upd_mode;   // issued read belongs to the update pass
        logic fin_y;      // round/saturate sum, form error
        logic fin_mu;     // form mu * error
        logic load_out;   // move result into output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic pipe_busy;  // MAC pipeline still holds work
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

// ===== rtl/lae_ram.sv =====
`timescale 1ns / 1ps
// lae_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module lae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lae_ctrl.sv =====
`timescale 1ns / 1ps
// lae_ctrl: sequencer for the filter pass, result rounding, update pass
// and output hand-off. Depends on lae_pkg.

module lae_ctrl #(
    parameter int MAX_TAPS = 32,
    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              adapt_enable,
    input  logic [IDX_W-1:0]  last_idx,
    input  lae_pkg::sts_t     sts,
    output lae_pkg::cmd_t     cmd,
    output logic [IDX_W-1:0]  idx
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILT = 3'd1;
    localparam logic [2:0] ST_FDRN = 3'd2;
    localparam logic [2:0] ST_FINY = 3'd3;
    localparam logic [2:0] ST_FINM = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_UDRN = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    k_next     = '0;
                    state_next = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.issue = 1'b1;
                if (k_reg == last_idx) begin
                    state_next = ST_FDRN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FDRN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FINY;
                end
            end
            ST_FINY: begin
                cmd.fin_y  = 1'b1;
                state_next = ST_FINM;
            end
            ST_FINM: begin
                cmd.fin_mu = 1'b1;
                k_next     = '0;
                state_next = adapt_enable ? ST_UPD : ST_DONE;
            end
            ST_UPD: begin
                cmd.issue    = 1'b1;
                cmd.upd_mode = 1'b1;
                if (k_reg == last_idx) begin
                    state_next = ST_UDRN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_UDRN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign idx      = k_reg;

endmodule

// ===== rtl/lae_datapath.sv =====
`timescale 1ns / 1ps
// lae_datapath: tap and coefficient RAMs, shared multiply pipeline,
// accumulator, rounding/saturation and output register.
// Depends on lae_pkg and lae_ram.

module lae_datapath #(
    parameter int MAX_TAPS = 32,
    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lae_pkg::cmd_t                       cmd,
    input  logic [IDX_W-1:0]                    idx,
    input  logic signed [lae_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [lae_pkg::SAMPLE_W-1:0] desired,
    input  logic                                adapt_enable,
    input  logic [lae_pkg::MU_W-1:0]            mu,
    output lae_pkg::sts_t                       sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [lae_pkg::SAMPLE_W-1:0] filtered,
    output logic signed [lae_pkg::ERR_W-1:0]    error
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = lae_pkg::PROD_W + $clog2(MAX_TAPS);
    localparam int YS_W  = ACC_W - lae_pkg::Y_SHIFT;
    localparam int SW    = lae_pkg::SAMPLE_W;
    localparam int CW    = lae_pkg::COEF_W;

    localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(32767);
    localparam logic signed [YS_W-1:0] Y_MIN = -YS_W'(32768);

    // Tap line bookkeeping: circular buffer, newest at head
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [MAX_TAPS-1:0] cval_reg;
    logic [IDX_W:0]      tap_wrap;
    logic [IDX_W-1:0]    tap_raddr;

    logic signed [SW-1:0] desired_reg;

    // Stage 1: RAM read data
    logic             v1_reg, upd1_reg, tv1_reg, cv1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [SW-1:0]    tap_rd;
    logic [CW-1:0]    coef_rd;
    logic signed [SW-1:0] tap1;
    logic signed [CW-1:0] coef1;
    logic signed [lae_pkg::ME_W-1:0]   op_a;
    logic signed [lae_pkg::PROD_W-1:0] prod;

    // Stage 2: product
    logic             v2_reg, upd2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic signed [lae_pkg::PROD_W-1:0] prod2_reg;
    logic signed [CW-1:0]              coef2_reg;
    logic signed [lae_pkg::PROD_W-1:0] rnd_u;

    // Stage 3: coefficient delta
    logic             v3_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic signed [lae_pkg::D_W-1:0] d3_reg;
    logic signed [CW-1:0]           coef3_reg;
    logic signed [CW:0]             c_sum;
    logic [CW-1:0]                  c_sat;

    // Accumulator and result
    logic signed [ACC_W-1:0] acc_reg, acc_rnd;
    logic signed [YS_W-1:0]  y_sh;
    logic signed [SW-1:0]    y_sat, y_reg;
    logic signed [lae_pkg::ERR_W-1:0] err_reg;
    logic signed [lae_pkg::ME_W-1:0]  me_reg;

    logic out_valid_reg;
    logic signed [SW-1:0]             filtered_reg;
    logic signed [lae_pkg::ERR_W-1:0] error_reg;

    // Physical address of tap k: head - k, modulo MAX_TAPS
    always_comb begin
        if (head_reg >= idx) begin
            tap_wrap = {1'b0, head_reg} - {1'b0, idx};
        end else begin
            tap_wrap = {1'b0, head_reg} + (IDX_W + 1)'(MAX_TAPS) - {1'b0, idx};
        end
        tap_raddr = tap_wrap[IDX_W-1:0];
        head_next = (head_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : head_reg + 1'b1;
    end

    lae_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_tap_ram (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (head_next),
        .wdata (sample),
        .raddr (tap_raddr),
        .rdata (tap_rd)
    );

    lae_ram #(.WIDTH(CW), .DEPTH(MAX_TAPS)) u_coef_ram (
        .aclk  (aclk),
        .we    (v3_reg),
        .waddr (idx3_reg),
        .wdata (c_sat),
        .raddr (idx),
        .rdata (coef_rd)
    );

    // Shared multiplier: coef*tap in the filter pass, (mu*err)*tap in update
    always_comb begin
        tap1  = tv1_reg ? $signed(tap_rd) : '0;
        coef1 = cv1_reg ? $signed(coef_rd) : '0;
        op_a  = upd1_reg ? me_reg : lae_pkg::ME_W'(coef1);
        prod  = op_a * tap1;
    end

    // Delta = floor((p + 2^18) / 2^19), then saturating coefficient add
    always_comb begin
        rnd_u = prod2_reg + lae_pkg::PROD_W'(1 << (lae_pkg::D_SHIFT - 1));
        c_sum = (CW + 1)'(coef3_reg) + (CW + 1)'(d3_reg);
        if (c_sum[CW] != c_sum[CW-1]) begin
            c_sat = c_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            c_sat = c_sum[CW-1:0];
        end
    end

    // Filter output: round half up, then clamp to Q1.15
    always_comb begin
        acc_rnd = acc_reg + ACC_W'(1 << (lae_pkg::Y_SHIFT - 1));
        y_sh    = acc_rnd[ACC_W-1:lae_pkg::Y_SHIFT];
        if (y_sh > Y_MAX) begin
            y_sat = 16'sh7fff;
        end else if (y_sh < Y_MIN) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_sh[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            fill_reg      <= '0;
            cval_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                head_reg <= head_next;
                if (fill_reg != CNT_W'(MAX_TAPS)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (v3_reg) begin
                cval_reg[idx3_reg] <= 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && upd2_reg;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            desired_reg <= desired;
        end
        upd1_reg  <= cmd.upd_mode;
        idx1_reg  <= idx;
        tv1_reg   <= (CNT_W'(idx) < fill_reg);
        cv1_reg   <= cval_reg[idx];

        upd2_reg  <= upd1_reg;
        idx2_reg  <= idx1_reg;
        prod2_reg <= prod;
        coef2_reg <= coef1;

        idx3_reg  <= idx2_reg;
        d3_reg    <= rnd_u[lae_pkg::PROD_W-1:lae_pkg::D_SHIFT];
        coef3_reg <= coef2_reg;

        if (cmd.accept) begin
            acc_reg <= '0;
        end else if (v2_reg && !upd2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod2_reg);
        end

        if (cmd.fin_y) begin
            y_reg   <= y_sat;
            err_reg <= adapt_enable ? (lae_pkg::ERR_W'(desired_reg) - lae_pkg::ERR_W'(y_sat))
                                    : '0;
        end
        if (cmd.fin_mu) begin
            me_reg <= $signed({1'b0, mu}) * err_reg;
        end
        if (cmd.load_out) begin
            filtered_reg <= y_reg;
            error_reg    <= err_reg;
        end
    end

    assign sts.pipe_busy = v1_reg | v2_reg | v3_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign filtered      = filtered_reg;
    assign error         = error_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_TAPS))
        else $error("tap fill count beyond tap line depth");

    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !(v1_reg || v2_reg || v3_reg))
        else $error("new item taken while MAC pipeline busy");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an unsent item");

    a_coef_write_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> $past(upd1_reg, 2))
        else $error("coefficient written from a filter-pass product");

endmodule

// ===== rtl/lms_adaptive_equalizer.sv =====
`timescale 1ns / 1ps
// lms_adaptive_equalizer: top level of the LMS adaptive FIR equalizer.
// Holds the APB register file; depends on lae_pkg, lae_ctrl, lae_datapath.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tdata: sample, desired
//  m_       | out       | m_tvalid / m_tready    | m_tdata: filtered, error
//  APB      | in        | psel, penable, pready  | adapt_enable, mu, taps_in_use
//
// Passes: the shared multiplier makes one pass over the N active taps for
//   the sum and, while training, one for the coefficient update, each a read per
//   cycle from the tap and coefficient RAMs; with adaptation off the update pass
//   is skipped.
// Reset: synchronous, active low; the tap line and coefficients read as zero
//   afterward (fill count and per-coefficient valid bits), no clearing pass.
// Stalls: the output register holds a result while m_tready is low; the next
//   item is taken and processed meanwhile, and only the final hand-off waits.

module lms_adaptive_equalizer #(
    parameter int MAX_TAPS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input item
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [15:0] sample, [31:16] desired
    // result item
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [15:0] filtered, [32:16] error, pad
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lae_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int TW    = (CNT_W > lae_pkg::TAPS_W) ? CNT_W : lae_pkg::TAPS_W;

    // Configuration registers
    logic                        adapt_reg;
    logic [lae_pkg::MU_W-1:0]    step_reg;
    logic [lae_pkg::TAPS_W-1:0]  taps_reg;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    // Active tap count, clamped to 1..MAX_TAPS
    logic [TW-1:0]    taps_ext, n_ext;
    logic [IDX_W-1:0] last_idx;

    lae_pkg::cmd_t cmd;
    lae_pkg::sts_t sts;
    logic [IDX_W-1:0] idx;

    logic signed [lae_pkg::SAMPLE_W-1:0] filtered;
    logic signed [lae_pkg::ERR_W-1:0]    error;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adapt_reg <= lae_pkg::ADAPT_RST;
            step_reg  <= lae_pkg::STEP_RST;
            taps_reg  <= lae_pkg::TAPS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                lae_pkg::REG_ADAPT: adapt_reg <= pwdata[0];
                lae_pkg::REG_STEP:  step_reg  <= pwdata[lae_pkg::MU_W-1:0];
                lae_pkg::REG_TAPS:  taps_reg  <= pwdata[lae_pkg::TAPS_W-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lae_pkg::REG_ADAPT: prdata = {31'd0, adapt_reg};
            lae_pkg::REG_STEP:  prdata = {16'd0, step_reg};
            lae_pkg::REG_TAPS:  prdata = {26'd0, taps_reg};
            default:            prdata = '0;
        endcase
    end

    // Zero acts as one tap, anything above the build size as MAX_TAPS
    always_comb begin
        taps_ext = TW'(taps_reg);
        if (taps_ext == '0) begin
            n_ext = TW'(1);
        end else if (taps_ext > TW'(MAX_TAPS)) begin
            n_ext = TW'(MAX_TAPS);
        end else begin
            n_ext = taps_ext;
        end
    end
    assign last_idx = IDX_W'(n_ext - 1'b1);

    lae_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .adapt_enable (adapt_reg),
        .last_idx     (last_idx),
        .sts          (sts),
        .cmd          (cmd),
        .idx          (idx)
    );

    lae_datapath #(.MAX_TAPS(MAX_TAPS)) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .idx          (idx),
        .sample       (s_tdata[15:0]),
        .desired      (s_tdata[31:16]),
        .adapt_enable (adapt_reg),
        .mu           (step_reg),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .filtered     (filtered),
        .error        (error)
    );

    assign m_tdata = {7'd0, error, filtered};

endmodule
